// ----- hw/rtl/gps_fix_smoother_macros.svh -----
// Assertion macros for the fix smoother.
`ifndef GPS_FIX_SMOOTHER_MACROS_SVH
`define GPS_FIX_SMOOTHER_MACROS_SVH
`ifndef SYNTHESIS
// Checked only out of reset.
`define GFS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define GFS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GFS_ASSERT(lbl, prop, msg)
`define GFS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- hw/rtl/gfs_pkg.sv -----
`timescale 1ns / 1ps
package gfs_pkg;
    localparam int LAT_W     = 28;
    localparam int LON_W     = 29;
    localparam int FRAC_EXT  = 16;
    localparam int POS_W     = 46;
    localparam int DEV_W     = 32;
    localparam int CFG_W     = 32;
    localparam int PASSES_W  = 4;
    localparam int REG_IDX_W = 2;
    localparam int MUL_A_W   = 46;
    localparam int MUL_B_W   = 32;
    localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
    localparam int SQ_IN_W   = 64;
    localparam int SQ_OUT_W  = 32;

    localparam logic [REG_IDX_W-1:0] REG_PROCESS_DEV  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_NOISE_OFFSET = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_GAIN_OFFSET  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_PASSES       = 2'd3;

    localparam logic [PASSES_W-1:0] PASSES_RESET = 4'd3;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;
endpackage

// ----- hw/rtl/gfs_if.sv -----
`timescale 1ns / 1ps
interface gfs_fix_in_if;
    logic                             valid;
    logic                             ready;
    logic signed [gfs_pkg::LAT_W-1:0] prev_lat;
    logic signed [gfs_pkg::LON_W-1:0] prev_lon;
    logic signed [gfs_pkg::LAT_W-1:0] cur_lat;
    logic signed [gfs_pkg::LON_W-1:0] cur_lon;

    modport source (output valid, prev_lat, prev_lon, cur_lat, cur_lon, input ready);
    modport sink (input valid, prev_lat, prev_lon, cur_lat, cur_lon, output ready);
endinterface

interface gfs_fix_out_if;
    logic                             valid;
    logic                             ready;
    logic signed [gfs_pkg::LAT_W-1:0] smoothed_lat;
    logic signed [gfs_pkg::LON_W-1:0] smoothed_lon;

    modport source (output valid, smoothed_lat, smoothed_lon, input ready);
    modport sink (input valid, smoothed_lat, smoothed_lon, output ready);
endinterface

// ----- hw/rtl/gps_fix_smoother.sv -----
`timescale 1ns / 1ps
// GPS fix smoother: scalar Kalman smoothing of a current fix against the fix
// before it. One fix pair is taken on fix_in, one smoothed fix leaves on
// fix_out. Each item runs 1..MAX_PASSES passes (the passes register, clamped).
// Each pass scales g and p down together before the gain is formed. When the
// gain reaches one, the deviation root and its product are skipped. Three
// units do the work. The bit-serial multiplier runs up to seven products per
// pass, each with start and done. The bit-serial square root runs up to three
// roots per pass. The 63-step restoring divide forms the gain.
// The next fix is taken once the last pass has handed its result to
// the output register; that register holds a result until fix_out takes it.
// Deviations and gains are unsigned fixed point with DEV_FRAC_BITS fraction
// bits. Registers are written through cfg_we/cfg_index/cfg_data: 0 process
// deviation, 1 noise offset, 2 gain offset, 3 pass count. The user must write
// them only while idle; the block itself does not enforce this. A zero
// process deviation seen at the start of an item reloads both the process
// and the model deviation with their reset values.

`include "gps_fix_smoother_macros.svh"

module gps_fix_smoother #(
    parameter int MAX_PASSES    = 5,
    parameter int DEV_FRAC_BITS = 30
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [gfs_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [gfs_pkg::CFG_W-1:0]          cfg_data,
    gfs_fix_in_if.sink                         fix_in,
    gfs_fix_out_if.source                      fix_out
);
    localparam int POS_W  = gfs_pkg::POS_W;
    localparam int DIFF_W = POS_W + 1;
    localparam int STEP_W = POS_W + 1;
    localparam int SUM_W  = POS_W + 2;
    localparam int DEV_W  = gfs_pkg::DEV_W;
    localparam int LAT_W  = gfs_pkg::LAT_W;
    localparam int LON_W  = gfs_pkg::LON_W;
    localparam int FE     = gfs_pkg::FRAC_EXT;
    localparam int FLD_W  = POS_W - FE;
    localparam int PW     = $clog2(MAX_PASSES + 1);
    localparam int SH_L   = (DEV_FRAC_BITS >= 31) ? DEV_FRAC_BITS - 31 : 0;
    localparam int SH_R   = (DEV_FRAC_BITS >= 31) ? 0 : 31 - DEV_FRAC_BITS;

    localparam longint unsigned DEV_ONE = 64'd1 << DEV_FRAC_BITS;
    localparam logic [DEV_W-1:0] PROCESS_DEV_RST = DEV_W'((DEV_ONE + 64'd500) / 64'd1000);
    localparam logic [DEV_W-1:0] MODEL_DEV_RST =
        DEV_W'((DEV_ONE * 64'd5698403 + 64'd5000000000) / 64'd10000000000);

    localparam logic [STEP_W-1:0]       STEP_MAX = {1'b1, {(STEP_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0] POS_MAX  = {3'b000, {(POS_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] POS_MIN  = {3'b111, {(POS_W-1){1'b0}}};
    localparam logic [FLD_W-1:0]        LAT_LIM  = FLD_W'(1) << (LAT_W - 1);
    localparam logic [FLD_W-1:0]        LON_LIM  = FLD_W'(1) << (LON_W - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_PP, S_MM, S_HSQ, S_NORM, S_GG, S_PS, S_DIV,
        S_QSQ, S_KSET, S_S31, S_GS, S_LAT, S_LON, S_OUT
    } state_t;

    // Configuration and model state
    logic [DEV_W-1:0]              process_dev_reg;
    logic [DEV_W-1:0]              noise_reg;
    logic [DEV_W-1:0]              gain_off_reg;
    logic [gfs_pkg::PASSES_W-1:0]  passes_reg;
    logic [DEV_W-1:0]              model_dev_reg;

    // Sequencer
    state_t                        state_reg;
    logic                          go_reg;
    logic [PW-1:0]                 pass_cnt_reg;
    logic [PW-1:0]                 npass_reg;
    logic [5:0]                    div_cnt_reg;

    // Per-pass datapath
    logic signed [POS_W-1:0]       prev_lat_reg, prev_lon_reg;
    logic signed [POS_W-1:0]       est_lat_reg, est_lon_reg;
    logic [63:0]                   p2_reg;
    logic [63:0]                   sum_reg;
    logic [DEV_W-1:0]              g_reg, gs_reg, ps_reg;
    logic [59:0]                   n_reg;
    logic [60:0]                   d_reg;
    logic [61:0]                   rem_reg;
    logic [62:0]                   q_reg;
    logic [DEV_W-1:0]              core_reg, k_reg, s31_reg, mnew_reg;

    // Output register
    logic                          out_valid_reg;
    logic signed [LAT_W-1:0]       out_lat_reg;
    logic signed [LON_W-1:0]       out_lon_reg;

    // Shared units
    logic                          mul_start, sq_start;
    logic [gfs_pkg::MUL_A_W-1:0]   mul_a;
    logic [gfs_pkg::MUL_B_W-1:0]   mul_b;
    logic [gfs_pkg::MUL_P_W-1:0]   mul_prod;
    gfs_pkg::unit_stat_t           mul_stat, sq_stat;
    logic [gfs_pkg::SQ_IN_W-1:0]   sq_op;
    logic [gfs_pkg::SQ_OUT_W-1:0]  sq_root;

    logic                          in_xfer;
    logic [PW-1:0]                 npass_clamp;
    logic signed [DIFF_W-1:0]      diff_lat, diff_lon;
    logic [POS_W-1:0]              mag_lat, mag_lon;
    logic [64:0]                   sum65;
    logic [60:0]                   d_next;
    logic [61:0]                   div_r;
    logic                          div_ge;
    logic [63:0]                   kq;
    logic [DEV_W-1:0]              k_next;
    logic [63:0]                   s_op;
    logic [PW-1:0]                 pass_inc;
    logic [FLD_W-1:0]              lat_fld, lon_fld;

    function automatic logic [DEV_W-1:0] sat32(input logic [64:0] v);
        return (|v[64:DEV_W]) ? {DEV_W{1'b1}} : v[DEV_W-1:0];
    endfunction

    // prev +/- floor(mag * k), step and estimate saturated
    function automatic logic signed [POS_W-1:0] move_pos(
        input logic signed [POS_W-1:0]        prev,
        input logic [gfs_pkg::MUL_P_W-1:0]    prod_raw,
        input logic                           neg
    );
        logic [gfs_pkg::MUL_P_W-1:0] prod_sh;
        logic [STEP_W-1:0]           step;
        logic signed [SUM_W-1:0]     sum;
        prod_sh = prod_raw >> DEV_FRAC_BITS;
        step    = (prod_sh > gfs_pkg::MUL_P_W'(STEP_MAX)) ? STEP_MAX : prod_sh[STEP_W-1:0];
        sum     = neg ? (SUM_W'(prev) - SUM_W'(step)) : (SUM_W'(prev) + SUM_W'(step));
        if (sum > POS_MAX)
            sum = POS_MAX;
        if (sum < POS_MIN)
            sum = POS_MIN;
        return sum[POS_W-1:0];
    endfunction

    // Drop the extra fraction toward zero and saturate to the field range
    function automatic logic [FLD_W-1:0] to_field(
        input logic signed [POS_W-1:0] pos,
        input logic [FLD_W-1:0]        lim
    );
        logic [POS_W-1:0] mag_full;
        logic [FLD_W-1:0] mag;
        mag_full = pos[POS_W-1] ? (POS_W'(0) - pos) : pos;
        mag      = mag_full[POS_W-1:FE];
        if (pos[POS_W-1])
            return FLD_W'(0) - ((mag > lim) ? lim : mag);
        return (mag > lim - FLD_W'(1)) ? lim - FLD_W'(1) : mag;
    endfunction

    assign in_xfer      = fix_in.valid && fix_in.ready;
    assign fix_in.ready = (state_reg == S_IDLE);

    assign npass_clamp = (passes_reg == '0) ? PW'(1) :
                         (passes_reg > gfs_pkg::PASSES_W'(MAX_PASSES)) ? PW'(MAX_PASSES) :
                         PW'(passes_reg);
    assign pass_inc    = pass_cnt_reg + PW'(1);

    assign diff_lat = DIFF_W'(est_lat_reg) - DIFF_W'(prev_lat_reg);
    assign diff_lon = DIFF_W'(est_lon_reg) - DIFF_W'(prev_lon_reg);
    assign mag_lat  = POS_W'(diff_lat[DIFF_W-1] ? -diff_lat : diff_lat);
    assign mag_lon  = POS_W'(diff_lon[DIFF_W-1] ? -diff_lon : diff_lon);

    assign sum65  = 65'(p2_reg) + 65'(mul_prod[63:0]);
    assign d_next = 61'(n_reg) + 61'(mul_prod[59:0]);
    assign div_r  = (div_cnt_reg == '0) ? rem_reg : {rem_reg[60:0], 1'b0};
    assign div_ge = div_r >= 62'(d_reg);

    // Gain core back to DEV_FRAC_BITS, then the offset
    assign kq     = (64'(core_reg) << SH_L) >> SH_R;
    assign k_next = sat32(65'(kq) + 65'(gain_off_reg));
    assign s_op   = (DEV_ONE - 64'(k_reg)) << (62 - DEV_FRAC_BITS);

    assign lat_fld = to_field(est_lat_reg, LAT_LIM);
    assign lon_fld = to_field(est_lon_reg, LON_LIM);

    // Unit operand selection; a unit starts on the first cycle of its state
    always_comb
    begin
        mul_a     = '0;
        mul_b     = '0;
        sq_op     = '0;
        mul_start = 1'b0;
        sq_start  = 1'b0;
        case (state_reg)
            S_PP:
            begin
                mul_a = gfs_pkg::MUL_A_W'(process_dev_reg);
                mul_b = process_dev_reg;
                mul_start = go_reg;
            end
            S_MM:
            begin
                mul_a = gfs_pkg::MUL_A_W'(model_dev_reg);
                mul_b = model_dev_reg;
                mul_start = go_reg;
            end
            S_GG:
            begin
                mul_a = gfs_pkg::MUL_A_W'(gs_reg);
                mul_b = gs_reg;
                mul_start = go_reg;
            end
            S_PS:
            begin
                mul_a = gfs_pkg::MUL_A_W'(ps_reg);
                mul_b = ps_reg;
                mul_start = go_reg;
            end
            S_GS:
            begin
                mul_a = gfs_pkg::MUL_A_W'(g_reg);
                mul_b = s31_reg;
                mul_start = go_reg;
            end
            S_LAT:
            begin
                mul_a = mag_lat;
                mul_b = k_reg;
                mul_start = go_reg;
            end
            S_LON:
            begin
                mul_a = mag_lon;
                mul_b = k_reg;
                mul_start = go_reg;
            end
            S_HSQ:
            begin
                sq_op = sum_reg;
                sq_start = go_reg;
            end
            S_QSQ:
            begin
                sq_op = {1'b0, q_reg};
                sq_start = go_reg;
            end
            S_S31:
            begin
                sq_op = s_op;
                sq_start = go_reg;
            end
            default:
            begin
                mul_start = 1'b0;
            end
        endcase
    end

    gfs_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .stat    (mul_stat),
        .product (mul_prod)
    );

    gfs_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sq_start),
        .operand (sq_op),
        .stat    (sq_stat),
        .root    (sq_root)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            go_reg          <= 1'b0;
            pass_cnt_reg    <= '0;
            npass_reg       <= PW'(1);
            div_cnt_reg     <= '0;
            process_dev_reg <= PROCESS_DEV_RST;
            noise_reg       <= '0;
            gain_off_reg    <= '0;
            passes_reg      <= gfs_pkg::PASSES_RESET;
            model_dev_reg   <= MODEL_DEV_RST;
            out_valid_reg   <= 1'b0;
            out_lat_reg     <= '0;
            out_lon_reg     <= '0;
            prev_lat_reg    <= '0;
            prev_lon_reg    <= '0;
            est_lat_reg     <= '0;
            est_lon_reg     <= '0;
            p2_reg          <= '0;
            sum_reg         <= '0;
            g_reg           <= '0;
            gs_reg          <= '0;
            ps_reg          <= '0;
            n_reg           <= '0;
            d_reg           <= '0;
            rem_reg         <= '0;
            q_reg           <= '0;
            core_reg        <= '0;
            k_reg           <= '0;
            s31_reg         <= '0;
            mnew_reg        <= '0;
        end
        else
        begin
            go_reg <= 1'b0;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    gfs_pkg::REG_PROCESS_DEV:  process_dev_reg <= cfg_data[DEV_W-1:0];
                    gfs_pkg::REG_NOISE_OFFSET: noise_reg       <= cfg_data[DEV_W-1:0];
                    gfs_pkg::REG_GAIN_OFFSET:  gain_off_reg    <= cfg_data[DEV_W-1:0];
                    gfs_pkg::REG_PASSES:       passes_reg      <= cfg_data[gfs_pkg::PASSES_W-1:0];
                    default:                   passes_reg      <= passes_reg;
                endcase
            end

            if (fix_out.valid && fix_out.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer)
                    begin
                        prev_lat_reg <= {{(POS_W-LAT_W-FE){fix_in.prev_lat[LAT_W-1]}},
                                         fix_in.prev_lat, {FE{1'b0}}};
                        prev_lon_reg <= {{(POS_W-LON_W-FE){fix_in.prev_lon[LON_W-1]}},
                                         fix_in.prev_lon, {FE{1'b0}}};
                        est_lat_reg  <= {{(POS_W-LAT_W-FE){fix_in.cur_lat[LAT_W-1]}},
                                         fix_in.cur_lat, {FE{1'b0}}};
                        est_lon_reg  <= {{(POS_W-LON_W-FE){fix_in.cur_lon[LON_W-1]}},
                                         fix_in.cur_lon, {FE{1'b0}}};
                        // zero process deviation: back to the reset model
                        if (process_dev_reg == '0)
                        begin
                            process_dev_reg <= PROCESS_DEV_RST;
                            model_dev_reg   <= MODEL_DEV_RST;
                        end
                        npass_reg    <= npass_clamp;
                        pass_cnt_reg <= '0;
                        state_reg    <= S_PP;
                        go_reg       <= 1'b1;
                    end
                end
                S_PP:
                begin
                    if (mul_stat.done)
                    begin
                        p2_reg    <= mul_prod[63:0];
                        state_reg <= S_MM;
                        go_reg    <= 1'b1;
                    end
                end
                S_MM:
                begin
                    if (mul_stat.done)
                    begin
                        sum_reg <= sum65[63:0];
                        if (sum65[64])
                        begin
                            // p^2 + m^2 overflows: root saturates, so does g
                            g_reg     <= {DEV_W{1'b1}};
                            gs_reg    <= {DEV_W{1'b1}};
                            ps_reg    <= process_dev_reg;
                            state_reg <= S_NORM;
                        end
                        else
                        begin
                            state_reg <= S_HSQ;
                            go_reg    <= 1'b1;
                        end
                    end
                end
                S_HSQ:
                begin
                    if (sq_stat.done)
                    begin
                        g_reg     <= sat32(65'(sq_root) + 65'(noise_reg));
                        gs_reg    <= sat32(65'(sq_root) + 65'(noise_reg));
                        ps_reg    <= process_dev_reg;
                        state_reg <= S_NORM;
                    end
                end
                S_NORM:
                begin
                    // scale g and p together below 2^30, one bit a cycle
                    if ((|gs_reg[DEV_W-1:30]) || (|ps_reg[DEV_W-1:30]))
                    begin
                        gs_reg <= gs_reg >> 1;
                        ps_reg <= ps_reg >> 1;
                    end
                    else
                    begin
                        state_reg <= S_GG;
                        go_reg    <= 1'b1;
                    end
                end
                S_GG:
                begin
                    if (mul_stat.done)
                    begin
                        n_reg     <= mul_prod[59:0];
                        state_reg <= S_PS;
                        go_reg    <= 1'b1;
                    end
                end
                S_PS:
                begin
                    if (mul_stat.done)
                    begin
                        d_reg       <= d_next;
                        rem_reg     <= 62'(n_reg);
                        q_reg       <= '0;
                        div_cnt_reg <= '0;
                        if (d_next == '0)
                        begin
                            core_reg  <= '0;
                            state_reg <= S_KSET;
                        end
                        else
                        begin
                            state_reg <= S_DIV;
                        end
                    end
                end
                S_DIV:
                begin
                    // q = floor(n * 2^62 / d), one quotient bit a cycle
                    rem_reg     <= div_ge ? (div_r - 62'(d_reg)) : div_r;
                    q_reg       <= {q_reg[61:0], div_ge};
                    div_cnt_reg <= div_cnt_reg + 6'd1;
                    if (div_cnt_reg == 6'd62)
                    begin
                        state_reg <= S_QSQ;
                        go_reg    <= 1'b1;
                    end
                end
                S_QSQ:
                begin
                    if (sq_stat.done)
                    begin
                        core_reg  <= sq_root;
                        state_reg <= S_KSET;
                    end
                end
                S_KSET:
                begin
                    k_reg <= k_next;
                    if (64'(k_next) < DEV_ONE)
                    begin
                        state_reg <= S_S31;
                    end
                    else
                    begin
                        // gain of one or more: model deviation collapses
                        mnew_reg  <= '0;
                        state_reg <= S_LAT;
                    end
                    go_reg <= 1'b1;
                end
                S_S31:
                begin
                    if (sq_stat.done)
                    begin
                        s31_reg   <= sq_root;
                        state_reg <= S_GS;
                        go_reg    <= 1'b1;
                    end
                end
                S_GS:
                begin
                    if (mul_stat.done)
                    begin
                        mnew_reg  <= sat32(65'(mul_prod >> 31));
                        state_reg <= S_LAT;
                        go_reg    <= 1'b1;
                    end
                end
                S_LAT:
                begin
                    if (mul_stat.done)
                    begin
                        est_lat_reg <= move_pos(prev_lat_reg, mul_prod, diff_lat[DIFF_W-1]);
                        state_reg   <= S_LON;
                        go_reg      <= 1'b1;
                    end
                end
                S_LON:
                begin
                    if (mul_stat.done)
                    begin
                        est_lon_reg   <= move_pos(prev_lon_reg, mul_prod, diff_lon[DIFF_W-1]);
                        model_dev_reg <= mnew_reg;
                        pass_cnt_reg  <= pass_inc;
                        if (pass_inc == npass_reg)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_PP;
                            go_reg    <= 1'b1;
                        end
                    end
                end
                S_OUT:
                begin
                    // wait for the output register to free up
                    if (!out_valid_reg || fix_out.ready)
                    begin
                        out_lat_reg   <= lat_fld[LAT_W-1:0];
                        out_lon_reg   <= lon_fld[LON_W-1:0];
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign fix_out.valid        = out_valid_reg;
    assign fix_out.smoothed_lat = out_lat_reg;
    assign fix_out.smoothed_lon = out_lon_reg;

    `GFS_ASSERT(a_mul_idle_start, mul_start |-> !mul_stat.busy, "multiplier started while busy")
    `GFS_ASSERT(a_sq_idle_start, sq_start |-> !sq_stat.busy, "square root started while busy")
    `GFS_ASSERT(a_pass_bound, (state_reg != S_IDLE && state_reg != S_OUT) |-> (pass_cnt_reg < npass_reg), "pass count past clamp")
    `GFS_ASSERT(a_gain_below_one, (state_reg == S_S31) |-> (64'(k_reg) < DEV_ONE), "deviation root with gain at one")
    `GFS_ASSERT_ALWAYS(a_one_unit, !(mul_start && sq_start), "both units started together")
endmodule

// ----- hw/rtl/gfs_mul.sv -----
`timescale 1ns / 1ps
// Shift-add multiplier, one bit of b per cycle.
module gfs_mul (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [gfs_pkg::MUL_A_W-1:0]   a,
    input  logic [gfs_pkg::MUL_B_W-1:0]   b,
    output gfs_pkg::unit_stat_t           stat,
    output logic [gfs_pkg::MUL_P_W-1:0]   product
);
    localparam int AW    = gfs_pkg::MUL_A_W;
    localparam int BW    = gfs_pkg::MUL_B_W;
    localparam int PW    = gfs_pkg::MUL_P_W;
    localparam int CNT_W = $clog2(BW);

    logic [AW-1:0]    a_reg;
    logic [PW-1:0]    p_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [AW:0]      sum;

    assign sum = {1'b0, p_reg[PW-1:BW]} + (p_reg[0] ? {1'b0, a_reg} : {(AW+1){1'b0}});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(BW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg <= a;
            p_reg <= {{AW{1'b0}}, b};
        end
        else if (busy_reg)
        begin
            p_reg <= {sum, p_reg[BW-1:1]};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign product   = p_reg;
endmodule

// ----- hw/rtl/gfs_sqrt.sv -----
`timescale 1ns / 1ps
// Restoring integer square root, one root bit per cycle.
module gfs_sqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [gfs_pkg::SQ_IN_W-1:0]   operand,
    output gfs_pkg::unit_stat_t           stat,
    output logic [gfs_pkg::SQ_OUT_W-1:0]  root
);
    localparam int IW    = gfs_pkg::SQ_IN_W;
    localparam int OW    = gfs_pkg::SQ_OUT_W;
    localparam int RW    = OW + 4;
    localparam int CNT_W = $clog2(OW);

    logic [IW-1:0]    v_reg;
    logic [RW-1:0]    rem_reg;
    logic [OW-1:0]    root_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;
    logic [RW-1:0]    rem_sh;
    logic [RW-1:0]    trial;
    logic             fits;

    assign rem_sh = {rem_reg[RW-3:0], v_reg[IW-1 -: 2]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(OW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg    <= operand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            v_reg    <= {v_reg[IW-3:0], 2'b00};
            rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[OW-2:0], fits};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign root      = root_reg;
endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// Smoothing testbench for gps_fix_smoother.
// The fix_check class keeps its own copy of the registers and of the model
// deviation and predicts each smoothed fix when a fix pair is accepted.
// Plain tasks drive the fix and register ports.

class fix_check;
    typedef struct {
        longint lat;
        longint lon;
    } smoothed_t;

    localparam longint unsigned DEV_ONE   = 64'd1 << 30;
    localparam longint unsigned PDEV_INIT = 64'd1073742;
    localparam longint unsigned MDEV_INIT = 64'd611861;
    localparam longint          POS_HI    = (64'sd1 <<< 45) - 1;
    localparam longint          POS_LO    = -(64'sd1 <<< 45);

    longint unsigned proc_dev;
    longint unsigned noise_off;
    longint unsigned gain_off;
    int unsigned     pass_cnt;
    longint unsigned model_dev;
    smoothed_t       expected_fixes[$];
    int              errors;

    function new();
        proc_dev  = PDEV_INIT;
        noise_off = 0;
        gain_off  = 0;
        pass_cnt  = 3;
        model_dev = MDEV_INIT;
        errors    = 0;
    endfunction

    function void write_reg(int idx, longint unsigned val);
        case (idx)
            gfs_pkg::REG_PROCESS_DEV:  proc_dev  = val & 64'hFFFF_FFFF;
            gfs_pkg::REG_NOISE_OFFSET: noise_off = val & 64'hFFFF_FFFF;
            gfs_pkg::REG_GAIN_OFFSET:  gain_off  = val & 64'hFFFF_FFFF;
            default:                   pass_cnt  = 32'(val & 64'hF);
        endcase
    endfunction

    function longint unsigned sat32(longint unsigned v);
        return (v > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : v;
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r = 0;
        longint unsigned b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // sqrt(g^2/(g^2+p^2)) with 31 fraction bits, restoring divide
    function longint unsigned gain_root(longint unsigned g, longint unsigned p);
        longint unsigned n;
        longint unsigned d;
        longint unsigned rem;
        longint unsigned q;
        while (((g | p) >> 30) != 0)
        begin
            g = g >> 1;
            p = p >> 1;
        end
        n = g * g;
        d = n + p * p;
        if (d == 0)
            return 0;
        rem = n;
        q = 0;
        if (rem >= d)
        begin
            rem = rem - d;
            q = 1;
        end
        for (int i = 0; i < 62; i++)
        begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= d)
            begin
                rem = rem - d;
                q = q | 1;
            end
        end
        return int_sqrt(q);
    endfunction

    function longint step_toward(longint prev, longint est, longint unsigned k);
        longint          diff = est - prev;
        bit              neg = diff < 0;
        longint unsigned mag = neg ? longint'(-diff) : diff;
        longint unsigned a = mag * (k >> 16);
        longint unsigned b = mag * (k & 64'hFFFF);
        longint unsigned prod;
        longint          res;
        prod = (a >> 14) + ((((a & 64'h3FFF) << 16) + b) >> 30);
        if (prod > (64'd1 << 46))
            prod = 64'd1 << 46;
        res = neg ? prev - longint'(prod) : prev + longint'(prod);
        if (res > POS_HI)
            res = POS_HI;
        if (res < POS_LO)
            res = POS_LO;
        return res;
    endfunction

    function longint out_field(longint pos, int w);
        longint unsigned mag = ((pos < 0) ? longint'(-pos) : pos) >> 16;
        longint unsigned hi = (64'd1 << (w - 1)) - 1;
        if (pos < 0)
            return (mag > hi + 1) ? -longint'(hi + 1) : -longint'(mag);
        return (mag > hi) ? longint'(hi) : longint'(mag);
    endfunction

    // accepted fix pair: run the passes and queue the smoothed fix
    function void note_fix(longint plat, longint plon, longint clat, longint clon);
        longint          pla = plat * 65536;
        longint          plo = plon * 65536;
        longint          ela = clat * 65536;
        longint          elo = clon * 65536;
        int unsigned     n = pass_cnt;
        longint unsigned p;
        longint unsigned sum;
        longint unsigned g;
        longint unsigned k;
        longint unsigned mnew;
        smoothed_t       res;
        if (proc_dev == 0)
        begin
            proc_dev  = PDEV_INIT;
            model_dev = MDEV_INIT;
        end
        if (n < 1)
            n = 1;
        if (n > 5)
            n = 5;
        for (int j = 0; j < n; j++)
        begin
            p = proc_dev;
            sum = p * p + model_dev * model_dev;
            g = sat32(((sum < p * p) ? 64'hFFFF_FFFF : int_sqrt(sum)) + noise_off);
            k = sat32((gain_root(g, p) >> 1) + gain_off);
            mnew = 0;
            if (k < DEV_ONE)
                mnew = sat32((g * int_sqrt((DEV_ONE - k) << 32)) >> 31);
            ela = step_toward(pla, ela, k);
            elo = step_toward(plo, elo, k);
            model_dev = mnew;
        end
        res.lat = out_field(ela, gfs_pkg::LAT_W);
        res.lon = out_field(elo, gfs_pkg::LON_W);
        expected_fixes.push_back(res);
    endfunction

    function void check_fix(longint lat, longint lon);
        smoothed_t exp_fix;
        if (expected_fixes.size() == 0)
        begin
            $display("%0t: unexpected smoothed fix lat=%0d lon=%0d", $time, lat, lon);
            errors++;
            return;
        end
        exp_fix = expected_fixes.pop_front();
        if (exp_fix.lat != lat)
        begin
            $display("%0t: smoothed_lat expected %0d actual %0d", $time, exp_fix.lat, lat);
            errors++;
        end
        if (exp_fix.lon != lon)
        begin
            $display("%0t: smoothed_lon expected %0d actual %0d", $time, exp_fix.lon, lon);
            errors++;
        end
    endfunction
endclass

module tb_top;
    localparam int     LAT_MAX    = 90000000;
    localparam int     LON_MAX    = 180000000;
    localparam longint CYCLE_CAP  = 64'd12000000;
    localparam int     LONG_HOLD  = 6000;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [gfs_pkg::REG_IDX_W-1:0] cfg_index;
    logic [gfs_pkg::CFG_W-1:0]     cfg_data;

    gfs_fix_in_if  fix_in_bus();
    gfs_fix_out_if fix_out_bus();

    gps_fix_smoother dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .fix_in    (fix_in_bus),
        .fix_out   (fix_out_bus)
    );

    fix_check checker_h = new();

    longint cycles = 0;
    bit     steady = 0;   // no gaps on either side while set
    bit     hold_req = 0; // ask the output side for one long stall

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run-length guard
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // output side: random stalls, one long hold-off on request
    initial
    begin
        int w;
        fix_out_bus.ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_req)
            begin
                fix_out_bus.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_req = 0;
            end
            w = steady ? 0 : $urandom_range(0, 5);
            if (w > 0)
            begin
                fix_out_bus.ready <= 1'b0;
                repeat (w) @(posedge clk);
            end
            fix_out_bus.ready <= 1'b1;
            do @(posedge clk); while (!fix_out_bus.valid);
            checker_h.check_fix(longint'(fix_out_bus.smoothed_lat),
                                longint'(fix_out_bus.smoothed_lon));
        end
    end

    // one fix pair; valid stays high across back-to-back transfers
    task automatic send_fix(int plat, int plon, int clat, int clon);
        int gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            fix_in_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        fix_in_bus.valid    <= 1'b1;
        fix_in_bus.prev_lat <= gfs_pkg::LAT_W'(plat);
        fix_in_bus.prev_lon <= gfs_pkg::LON_W'(plon);
        fix_in_bus.cur_lat  <= gfs_pkg::LAT_W'(clat);
        fix_in_bus.cur_lon  <= gfs_pkg::LON_W'(clon);
        do @(posedge clk); while (!fix_in_bus.ready);
        checker_h.note_fix(plat, plon, clat, clon);
    endtask

    // stop offering and let every pending fix come out
    task automatic drain();
        fix_in_bus.valid <= 1'b0;
        while (checker_h.expected_fixes.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(int idx, longint unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= gfs_pkg::REG_IDX_W'(idx);
        cfg_data  <= gfs_pkg::CFG_W'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
        checker_h.write_reg(idx, val);
        @(posedge clk);
    endtask

    function automatic int clip(int v, int lim);
        return (v > lim) ? lim : ((v < -lim) ? -lim : v);
    endfunction

    function automatic int rand_coord(int lim);
        return int'($urandom_range(0, 2 * lim)) - lim;
    endfunction

    function automatic int edge_coord(int lim);
        case ($urandom_range(0, 4))
            0: return lim;
            1: return -lim;
            2: return 0;
            3: return 1;
            default: return -1;
        endcase
    endfunction

    // mostly plausible tracks (small jumps); the rest noise and outliers
    task automatic send_random_fix();
        int plat;
        int plon;
        int clat;
        int clon;
        int sel = $urandom_range(0, 9);
        int span = ($urandom_range(0, 3) == 0) ? 5000000 : 3000;
        plat = rand_coord(LAT_MAX);
        plon = rand_coord(LON_MAX);
        if (sel < 7)
        begin
            clat = clip(plat + rand_coord(span), LAT_MAX);
            clon = clip(plon + rand_coord(span), LON_MAX);
        end
        else if (sel < 9)
        begin
            clat = rand_coord(LAT_MAX);
            clon = rand_coord(LON_MAX);
        end
        else
        begin
            plat = edge_coord(LAT_MAX);
            plon = edge_coord(LON_MAX);
            clat = edge_coord(LAT_MAX);
            clon = edge_coord(LON_MAX);
        end
        send_fix(plat, plon, clat, clon);
    endtask

    function automatic longint unsigned rand_dev();
        case ($urandom_range(0, 7))
            0: return 0;
            1: return 64'hFFFF_FFFF;
            2: return $urandom();
            3: return $urandom_range(1, 1 << 16);
            default: return $urandom_range(1 << 16, 1 << 29);
        endcase
    endfunction

    initial
    begin
        int n_items;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_index           = '0;
        cfg_data            = '0;
        fix_in_bus.valid    = 1'b0;
        fix_in_bus.prev_lat = '0;
        fix_in_bus.prev_lon = '0;
        fix_in_bus.cur_lat  = '0;
        fix_in_bus.cur_lon  = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, coordinate extremes
        send_fix(0, 0, 0, 0);
        send_fix(LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX);
        send_fix(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
        send_fix(LAT_MAX, -LON_MAX, LAT_MAX, -LON_MAX);
        send_fix(-1, 1, 1, -1);
        send_fix(12345678, -98765432, 12345900, -98765000);
        drain();

        // zero process deviation reloads both deviations
        write_reg(gfs_pkg::REG_PROCESS_DEV, 0);
        send_fix(1000, 2000, 5000, -7000);
        send_fix(-LAT_MAX, LON_MAX, LAT_MAX, -LON_MAX);
        drain();

        // saturating noise deviation, fewest passes (0 clamps to 1)
        write_reg(gfs_pkg::REG_PROCESS_DEV, 64'hFFFF_FFFF);
        write_reg(gfs_pkg::REG_NOISE_OFFSET, 64'hFFFF_FFFF);
        write_reg(gfs_pkg::REG_PASSES, 0);
        send_fix(LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX);
        send_fix(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
        drain();

        // gain of one or more: model deviation collapses to zero
        write_reg(gfs_pkg::REG_PROCESS_DEV, 1);
        write_reg(gfs_pkg::REG_NOISE_OFFSET, 0);
        write_reg(gfs_pkg::REG_GAIN_OFFSET, 64'hFFFF_FFFF);
        write_reg(gfs_pkg::REG_PASSES, 15);
        send_fix(LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX);
        send_fix(-LAT_MAX, -LON_MAX, LAT_MAX, LON_MAX);
        send_fix(100, 200, 300, 400);
        drain();

        // moderate gain offset, most passes
        write_reg(gfs_pkg::REG_GAIN_OFFSET, 64'd1 << 29);
        write_reg(gfs_pkg::REG_PASSES, 5);
        send_fix(50000000, 100000000, 50001000, 99999000);
        send_fix(0, 0, -LAT_MAX, LON_MAX);
        drain();

        // random phases; the first runs with a long output stall
        for (int ph = 0; ph < 30; ph++)
        begin
            write_reg(gfs_pkg::REG_PROCESS_DEV, rand_dev());
            write_reg(gfs_pkg::REG_NOISE_OFFSET,
                      ($urandom_range(0, 2) == 0) ? rand_dev() : 0);
            write_reg(gfs_pkg::REG_GAIN_OFFSET,
                      ($urandom_range(0, 3) == 0) ? rand_dev() : 0);
            write_reg(gfs_pkg::REG_PASSES, ($urandom_range(0, 3) != 0) ?
                      $urandom_range(0, 3) : $urandom_range(4, 15));
            steady = ($urandom_range(0, 4) == 0);
            if (ph == 0)
                hold_req = 1;
            n_items = 50;
            for (int i = 0; i < n_items; i++)
                send_random_fix();
            drain();
        end

        repeat (50) @(posedge clk);
        if (checker_h.errors == 0 && checker_h.expected_fixes.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/gfs_pkg.sv
hw/rtl/gfs_if.sv
hw/rtl/gfs_mul.sv
hw/rtl/gfs_sqrt.sv
hw/rtl/gps_fix_smoother.sv
verif/tb_top.sv
